/* hdl/fdse_pkg.sv */
// ----------------------------------------------------------------------------
// fdse_pkg
// Shared types and codes of the data stack engine.
// ----------------------------------------------------------------------------
package fdse_pkg;

    localparam int VALUE_W = 32;
    localparam int FUNC_W  = 3;
    localparam int ERR_W   = 2;
    localparam int COUNT_W = 7;

    localparam logic [FUNC_W-1:0] FUNC_PUSH  = 3'd0;
    localparam logic [FUNC_W-1:0] FUNC_DROP  = 3'd1;
    localparam logic [FUNC_W-1:0] FUNC_PICK  = 3'd2;
    localparam logic [FUNC_W-1:0] FUNC_ROLL  = 3'd3;
    localparam logic [FUNC_W-1:0] FUNC_DEPTH = 3'd4;

    localparam logic [ERR_W-1:0] ERR_OK        = 2'd0;
    localparam logic [ERR_W-1:0] ERR_UNDERFLOW = 2'd1;
    localparam logic [ERR_W-1:0] ERR_OVERFLOW  = 2'd2;
    localparam logic [ERR_W-1:0] ERR_INDEX     = 2'd3;

    typedef enum logic [2:0] {
        CELL_HOLD,
        CELL_PUSH,
        CELL_POP,
        CELL_PICK,
        CELL_ROLL
    } t_cell_op;

    // broadcast to every cell of the chain
    typedef struct packed {
        t_cell_op            op;
        logic [VALUE_W-1:0]  top_in;
    } t_cell_ctrl;

    typedef enum logic {
        ST_IDLE,
        ST_MOVE
    } t_state;

    typedef struct packed {
        logic [VALUE_W-1:0]  top_value;
        logic [COUNT_W-1:0]  stack_count;
        logic [ERR_W-1:0]    error_code;
    } t_result;

endpackage

/* hdl/fdse_cell.sv */
// ----------------------------------------------------------------------------
// fdse_cell
// One stack slot. Cell 0 is the top; data moves to the neighbor cells.
// ----------------------------------------------------------------------------
module fdse_cell
    import fdse_pkg::*;
#(
    parameter int AW  = 6,
    parameter int IDX = 0
) (
    input  logic               i_clk,
    input  t_cell_ctrl         i_ctrl,
    input  logic [AW-1:0]      i_tgt,
    input  logic [VALUE_W-1:0] i_sel,
    input  logic [VALUE_W-1:0] i_up,
    input  logic [VALUE_W-1:0] i_down,
    output logic [VALUE_W-1:0] o_value,
    output logic [VALUE_W-1:0] o_match
);

    localparam logic [AW-1:0] MY_IDX = AW'(IDX);
    localparam bit            IS_TOP = (IDX == 0);

    logic [VALUE_W-1:0] r_value;
    logic [VALUE_W-1:0] n_value;

    always_comb begin
        n_value = r_value;
        case (i_ctrl.op)
            CELL_PUSH: n_value = i_up;
            CELL_POP:  n_value = i_down;
            CELL_PICK: begin
                if (IS_TOP) n_value = i_sel;
            end
            CELL_ROLL: begin
                // top takes the picked entry, cells at or below it close the gap
                if (IS_TOP) begin
                    n_value = i_sel;
                end else if (MY_IDX >= i_tgt) begin
                    n_value = i_down;
                end
            end
            default: n_value = r_value;
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_value <= n_value;
    end

    assign o_value = r_value;
    assign o_match = (MY_IDX == i_tgt) ? r_value : '0;

endmodule

/* hdl/fdse_chain.sv */
// ----------------------------------------------------------------------------
// fdse_chain
// Row of stack cells with an OR-combined select bus for pick and roll.
// ----------------------------------------------------------------------------
module fdse_chain
    import fdse_pkg::*;
#(
    parameter int STACK_DEPTH = 64,
    parameter int AW          = 6
) (
    input  logic               i_clk,
    input  t_cell_ctrl         i_ctrl,
    input  logic [AW-1:0]      i_tgt,
    output logic [VALUE_W-1:0] o_top,
    output logic [VALUE_W-1:0] o_second,
    output logic [VALUE_W-1:0] o_sel
);

    logic [VALUE_W-1:0] w_val   [STACK_DEPTH];
    logic [VALUE_W-1:0] w_match [STACK_DEPTH];

    for (genvar g = 0; g < STACK_DEPTH; g++) begin : g_cell
        logic [VALUE_W-1:0] w_up;
        logic [VALUE_W-1:0] w_down;

        if (g == 0) begin : g_first
            assign w_up = i_ctrl.top_in;
        end else begin : g_mid_up
            assign w_up = w_val[g-1];
        end

        if (g == STACK_DEPTH - 1) begin : g_last
            assign w_down = w_val[g];
        end else begin : g_mid_down
            assign w_down = w_val[g+1];
        end

        fdse_cell #(
            .AW  (AW),
            .IDX (g)
        ) u_cell (
            .i_clk   (i_clk),
            .i_ctrl  (i_ctrl),
            .i_tgt   (i_tgt),
            .i_sel   (o_sel),
            .i_up    (w_up),
            .i_down  (w_down),
            .o_value (w_val[g]),
            .o_match (w_match[g])
        );
    end

    // only the addressed cell drives its value onto the bus; all others drive zero
    always_comb begin
        o_sel = '0;
        for (int k = 0; k < STACK_DEPTH; k++) begin
            o_sel = o_sel | w_match[k];
        end
    end

    assign o_top    = w_val[0];
    assign o_second = w_val[1];

endmodule

/* hdl/forth_data_stack_engine.sv */
// ----------------------------------------------------------------------------
// forth_data_stack_engine
// Data stack with push, drop, pick, roll and depth operations.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel i_in_valid / o_in_ready carries one stack operation per
//   item (i_func, i_push_value). Output channel o_out_valid / i_out_ready
//   returns one result item per operation: new top, entry count, error code.
//   The stack is a row of cells with the top in cell 0; push and drop shift
//   the whole row by one cell.
//   Push, drop, depth, unused codes and every error: result written to the
//   output queue on acceptance, next item accepted in the following cycle
//   unless two results are waiting. Pick and roll that pass the index
//   check go through ST_IDLE, which latches the target cell, then ST_MOVE,
//   which reads it over the select bus and moves it to the top.
//   Results go into a two-item output queue, so a stalled receiver blocks
//   input only once two results are waiting.
//   Reset empties the stack and the queue; cell contents are not cleared.
//   Any error leaves the stack unchanged.
// ----------------------------------------------------------------------------
module forth_data_stack_engine
    import fdse_pkg::*;
#(
    parameter int STACK_DEPTH = 64
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_ready,
    input  logic [FUNC_W-1:0]   i_func,
    input  logic [VALUE_W-1:0]  i_push_value,
    output logic                o_out_valid,
    input  logic                i_out_ready,
    output logic [VALUE_W-1:0]  o_top_value,
    output logic [COUNT_W-1:0]  o_stack_count,
    output logic [ERR_W-1:0]    o_error_code
);

    localparam int AW = $clog2(STACK_DEPTH);
    localparam int CW = $clog2(STACK_DEPTH + 1);
    localparam logic [CW-1:0] FULL = CW'(STACK_DEPTH);

    t_state          r_state, n_state;
    logic [CW-1:0]   r_count, n_count;
    logic [AW-1:0]   r_tgt, n_tgt;
    logic            r_roll, n_roll;

    t_cell_ctrl      w_ctrl;
    logic [AW-1:0]   w_tgt;
    logic [VALUE_W-1:0] w_top, w_second, w_sel;

    logic            w_accept;
    logic            w_go_move;
    logic            w_res_we;
    t_result         w_res;

    logic            w_empty, w_full, w_bad_idx;
    logic [CW-1:0]   w_rem;

    // output queue
    t_result         r_q [2];
    logic            r_wp, r_rp;
    logic [1:0]      r_ocnt;
    logic            w_pop;

    fdse_chain #(
        .STACK_DEPTH (STACK_DEPTH),
        .AW          (AW)
    ) u_chain (
        .i_clk    (i_clk),
        .i_ctrl   (w_ctrl),
        .i_tgt    (w_tgt),
        .o_top    (w_top),
        .o_second (w_second),
        .o_sel    (w_sel)
    );

    assign o_in_ready = (r_state == ST_IDLE) && (r_ocnt != 2'd2);
    assign w_accept   = i_in_valid && o_in_ready;

    assign w_empty   = (r_count == '0);
    assign w_full    = (r_count == FULL);
    assign w_rem     = r_count - CW'(1);
    // index sits in the top cell; it must address one of the entries below it
    assign w_bad_idx = w_top[VALUE_W-1] || (w_top >= VALUE_W'(w_rem));

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (w_accept && w_go_move) n_state = ST_MOVE;
            end
            ST_MOVE: n_state = ST_IDLE;
            default: n_state = ST_IDLE;
        endcase
    end

    // outputs of the controller
    always_comb begin
        w_ctrl.op     = CELL_HOLD;
        w_ctrl.top_in = i_push_value;
        w_tgt         = r_tgt;
        w_go_move     = 1'b0;
        w_res_we      = 1'b0;
        n_count       = r_count;
        n_tgt         = r_tgt;
        n_roll        = r_roll;
        w_res.error_code = ERR_OK;
        w_res.top_value  = w_empty ? '0 : w_top;
        unique case (r_state)
            ST_IDLE: begin
                unique case (i_func) inside
                    FUNC_PUSH, FUNC_DEPTH: begin
                        if (w_full) begin
                            w_res.error_code = ERR_OVERFLOW;
                        end else begin
                            if (i_func == FUNC_DEPTH) w_ctrl.top_in = VALUE_W'(r_count);
                            w_ctrl.op       = CELL_PUSH;
                            n_count         = r_count + CW'(1);
                            w_res.top_value = w_ctrl.top_in;
                        end
                    end
                    FUNC_DROP: begin
                        if (w_empty) begin
                            w_res.error_code = ERR_UNDERFLOW;
                        end else begin
                            w_ctrl.op       = CELL_POP;
                            n_count         = w_rem;
                            w_res.top_value = (w_rem == '0) ? '0 : w_second;
                        end
                    end
                    FUNC_PICK, FUNC_ROLL: begin
                        if (w_empty) begin
                            w_res.error_code = ERR_UNDERFLOW;
                        end else if (w_bad_idx) begin
                            w_res.error_code = ERR_INDEX;
                        end else begin
                            w_go_move = 1'b1;
                            n_tgt     = w_top[AW-1:0] + AW'(1);
                            n_roll    = (i_func == FUNC_ROLL);
                        end
                    end
                    default: ;
                endcase
                if (!w_accept) begin
                    w_ctrl.op = CELL_HOLD;
                    n_count   = r_count;
                    n_tgt     = r_tgt;
                    n_roll    = r_roll;
                end
                w_res_we = w_accept && !w_go_move;
            end
            ST_MOVE: begin
                w_ctrl.op       = r_roll ? CELL_ROLL : CELL_PICK;
                w_res.top_value = w_sel;
                n_count         = r_roll ? w_rem : r_count;
                w_res_we        = 1'b1;
            end
            default: ;
        endcase
        w_res.stack_count = COUNT_W'(n_count);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_count <= '0;
            r_roll  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            r_roll  <= n_roll;
        end
    end

    always_ff @(posedge i_clk) begin
        r_tgt <= n_tgt;
    end

    assign w_pop = o_out_valid && i_out_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp   <= 1'b0;
            r_rp   <= 1'b0;
            r_ocnt <= '0;
        end else begin
            if (w_res_we) r_wp <= ~r_wp;
            if (w_pop)    r_rp <= ~r_rp;
            r_ocnt <= r_ocnt + 2'(w_res_we) - 2'(w_pop);
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_res_we) r_q[r_wp] <= w_res;
    end

    assign o_out_valid   = (r_ocnt != '0);
    assign o_top_value   = r_q[r_rp].top_value;
    assign o_stack_count = r_q[r_rp].stack_count;
    assign o_error_code  = r_q[r_rp].error_code;

endmodule

/* hdl/fdse_checker.sv */
// ----------------------------------------------------------------------------
// fdse_checker
// Port-level checks of the data stack engine, bound to the top level.
// ----------------------------------------------------------------------------
module fdse_checker
    import fdse_pkg::*;
#(
    parameter int STACK_DEPTH = 64
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                o_out_valid,
    input  logic                i_out_ready,
    input  logic [VALUE_W-1:0]  o_top_value,
    input  logic [COUNT_W-1:0]  o_stack_count,
    input  logic [ERR_W-1:0]    o_error_code
);

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_top_value)
            && $stable(o_stack_count) && $stable(o_error_code))
        else $error("result item changed while stalled");

    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result item present after reset");

    a_empty_top: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_stack_count == '0 |-> o_top_value == '0)
        else $error("empty stack shows nonzero top");

    a_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_error_code == ERR_UNDERFLOW |-> o_stack_count == '0)
        else $error("underflow reported with entries held");

    a_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_error_code == ERR_OVERFLOW
            |-> o_stack_count == COUNT_W'(STACK_DEPTH))
        else $error("overflow reported on a stack that is not full");

endmodule

bind forth_data_stack_engine fdse_checker #(
    .STACK_DEPTH (STACK_DEPTH)
) u_fdse_checker (.*);

/* dv/forth_data_stack_engine_tb.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// forth_data_stack_engine_tb
// Drives stack operations with random gaps on both channels, including
// fill and drain phases and a long output stall, and checks every result
// against a shadow stack that is updated as each operation is accepted.
// ----------------------------------------------------------------------------
module forth_data_stack_engine_tb
    import fdse_pkg::*;
();

    localparam int DEPTH       = 64;
    localparam int RANDOM_OPS  = 1400;
    localparam int QUIET_LIMIT = 3000;
    localparam int LONG_HOLD   = 400;

    // func codes with no operation behind them
    localparam logic [FUNC_W-1:0] FUNC_SPARE_LO  = 3'd5;
    localparam logic [FUNC_W-1:0] FUNC_SPARE_MID = 3'd6;
    localparam logic [FUNC_W-1:0] FUNC_SPARE_HI  = 3'd7;

    typedef enum int {MIX_EVEN, MIX_FILL, MIX_DRAIN} t_mix;

    class stack_shadow;

        logic [VALUE_W-1:0] cells [DEPTH];
        int unsigned        held;
        int unsigned        peak_held;
        t_result            want_q [$];
        int                 mismatches;
        int                 results_seen;
        int                 ops_noted;
        int                 code_seen [4];

        function new();
            held         = 0;
            peak_held    = 0;
            mismatches   = 0;
            results_seen = 0;
            ops_noted    = 0;
            foreach (code_seen[i]) code_seen[i] = 0;
        endfunction

        // apply one accepted operation and queue the result it must produce
        function void note_op(logic [FUNC_W-1:0] func, logic [VALUE_W-1:0] lit);
            logic [ERR_W-1:0]   err;
            logic [VALUE_W-1:0] idx;
            logic [VALUE_W-1:0] moved;
            int unsigned        rem;
            int unsigned        pos;
            t_result            res;
            err = ERR_OK;
            ops_noted++;
            case (func) inside
                FUNC_PUSH, FUNC_DEPTH: begin
                    if (held >= DEPTH) begin
                        err = ERR_OVERFLOW;
                    end else begin
                        cells[held] = (func == FUNC_PUSH) ? lit : VALUE_W'(held);
                        held++;
                    end
                end
                FUNC_DROP: begin
                    if (held == 0) err = ERR_UNDERFLOW;
                    else held--;
                end
                FUNC_PICK, FUNC_ROLL: begin
                    if (held == 0) begin
                        err = ERR_UNDERFLOW;
                    end else begin
                        rem = held - 1;
                        idx = cells[rem];
                        // negative or reaching past the bottom once the index is popped
                        if (idx[VALUE_W-1] || idx >= VALUE_W'(rem)) begin
                            err = ERR_INDEX;
                        end else begin
                            pos   = rem - 1 - int'(idx);
                            moved = cells[pos];
                            if (func == FUNC_PICK) begin
                                cells[rem] = moved;
                            end else begin
                                for (int i = pos; i < int'(rem) - 1; i++)
                                    cells[i] = cells[i+1];
                                cells[rem-1] = moved;
                                held = rem;
                            end
                        end
                    end
                end
                default: ;
            endcase
            if (held > peak_held) peak_held = held;
            res.top_value   = (held == 0) ? '0 : cells[held-1];
            res.stack_count = COUNT_W'(held);
            res.error_code  = err;
            want_q.insert(want_q.size(), res);
        endfunction

        function void check_result(logic [VALUE_W-1:0] top, logic [COUNT_W-1:0] cnt,
                                   logic [ERR_W-1:0] err);
            t_result want;
            results_seen++;
            if (want_q.size() == 0) begin
                mismatches++;
                $error("result item with nothing expected: top %0d count %0d err %0d",
                       $signed(top), cnt, err);
                return;
            end
            want = want_q[0];
            want_q.delete(0);
            code_seen[want.error_code]++;
            if (top !== want.top_value) begin
                mismatches++;
                if (mismatches <= 40)
                    $error("top_value: expected %0d, actual %0d",
                           $signed(want.top_value), $signed(top));
            end
            if (cnt !== want.stack_count) begin
                mismatches++;
                if (mismatches <= 40)
                    $error("stack_count: expected %0d, actual %0d", want.stack_count, cnt);
            end
            if (err !== want.error_code) begin
                mismatches++;
                if (mismatches <= 40)
                    $error("error_code: expected %0d, actual %0d", want.error_code, err);
            end
        endfunction

    endclass

    logic               i_clk;
    logic               i_rst_n;
    logic               i_in_valid;
    logic               o_in_ready;
    logic [FUNC_W-1:0]  i_func;
    logic [VALUE_W-1:0] i_push_value;
    logic               o_out_valid;
    logic               i_out_ready;
    logic [VALUE_W-1:0] o_top_value;
    logic [COUNT_W-1:0] o_stack_count;
    logic [ERR_W-1:0]   o_error_code;

    stack_shadow sb;

    bit steady;          // no idling on either side
    bit long_hold_req;
    int quiet_cycles;

    forth_data_stack_engine #(
        .STACK_DEPTH (DEPTH)
    ) i_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_in_valid),
        .o_in_ready    (o_in_ready),
        .i_func        (i_func),
        .i_push_value  (i_push_value),
        .o_out_valid   (o_out_valid),
        .i_out_ready   (i_out_ready),
        .o_top_value   (o_top_value),
        .o_stack_count (o_stack_count),
        .o_error_code  (o_error_code)
    );

    initial begin
        i_clk = 1'b0;
    end

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    function automatic int next_gap();
        int r;
        if (steady) return 0;
        r = $urandom_range(0, 19);
        if (r == 0) return $urandom_range(8, 30);
        if (r <= 3) return $urandom_range(1, 3);
        return 0;
    endfunction

    function automatic logic [VALUE_W-1:0] literal();
        case ($urandom_range(0, 9))
            0:       return 32'h8000_0000;
            1:       return 32'h7fff_ffff;
            2:       return '0;
            3:       return '1;
            default: return $urandom;
        endcase
    endfunction

    task automatic send_op(input logic [FUNC_W-1:0] func, input logic [VALUE_W-1:0] value);
        int gap;
        gap = next_gap();
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_func       <= func;
        i_push_value <= value;
        i_in_valid   <= 1'b1;
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
        sb.note_op(func, value);
    endtask

    // index then pick/roll; well formed unless asked otherwise
    task automatic send_select(input logic [FUNC_W-1:0] func, input bit bad_index);
        int unsigned        cnt;
        logic [VALUE_W-1:0] idx;
        cnt = sb.held;
        if (bad_index)
            idx = $urandom_range(0, 1) ? (32'h8000_0000 | $urandom)
                                       : VALUE_W'(cnt + $urandom_range(0, 3));
        else
            idx = VALUE_W'($urandom_range(0, cnt - 1));
        send_op(FUNC_PUSH, idx);
        send_op(func, $urandom);
    endtask

    task automatic random_op(input t_mix mix);
        int               r;
        int               push_w;
        int               drop_w;
        int               k;
        logic [FUNC_W-1:0] sel;
        push_w = (mix == MIX_FILL) ? 70 : (mix == MIX_DRAIN) ? 10 : 30;
        drop_w = (mix == MIX_FILL) ? 5  : (mix == MIX_DRAIN) ? 55 : 20;
        r = $urandom_range(0, 99);
        if (r < push_w) begin
            send_op(FUNC_PUSH, literal());
        end else if (r < push_w + drop_w) begin
            send_op(FUNC_DROP, $urandom);
        end else if (r < push_w + drop_w + 5) begin
            send_op(FUNC_DEPTH, $urandom);
        end else if (r < push_w + drop_w + 7) begin
            send_op(FUNC_W'($urandom_range(FUNC_SPARE_LO, FUNC_SPARE_HI)), $urandom);
        end else begin
            sel = $urandom_range(0, 1) ? FUNC_PICK : FUNC_ROLL;
            k   = $urandom_range(0, 9);
            if (k < 7 && sb.held > 0 && sb.held < DEPTH)
                send_select(sel, 1'b0);
            else if (k == 7 && sb.held < DEPTH)
                send_select(sel, 1'b1);
            else
                send_op(sel, $urandom);
        end
    endtask

    // receiver: random stalls, plus one long hold-off on request
    initial begin : out_side
        int stall_left;
        stall_left  = 0;
        i_out_ready = 1'b0;
        @(posedge i_clk);
        while (!i_rst_n) @(posedge i_clk);
        forever begin
            if (long_hold_req) begin
                long_hold_req = 1'b0;
                stall_left    = LONG_HOLD;
            end else if (stall_left == 0 && !steady && $urandom_range(0, 7) == 0) begin
                stall_left = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 60)
                                                         : $urandom_range(1, 4);
            end
            if (stall_left > 0) begin
                i_out_ready <= 1'b0;
                stall_left--;
            end else begin
                i_out_ready <= 1'b1;
            end
            @(posedge i_clk);
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && i_out_ready)
            sb.check_result(o_top_value, o_stack_count, o_error_code);
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (i_in_valid && o_in_ready) || (o_out_valid && i_out_ready))
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= QUIET_LIMIT) begin
            $display("timeout: no item moved for %0d cycles", QUIET_LIMIT);
            $display("FAILURE");
            $finish;
        end
    end

    initial begin : stimulus
        int   phase;
        int   len;
        int   base;
        t_mix mix;
        sb            = new();
        steady        = 1'b0;
        long_hold_req = 1'b0;
        quiet_cycles  = 0;
        i_rst_n       = 1'b0;
        i_in_valid    = 1'b0;
        i_func        = FUNC_PUSH;
        i_push_value  = '0;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // empty stack cases, extremes, dup, bad indexes, rolls, unused codes
        send_op(FUNC_DROP, $urandom);
        send_op(FUNC_PICK, $urandom);
        send_op(FUNC_ROLL, $urandom);
        send_op(FUNC_DEPTH, $urandom);
        send_op(FUNC_PICK, $urandom);          // only the index is held
        send_op(FUNC_PUSH, 32'h7fff_ffff);
        send_op(FUNC_PUSH, 32'h8000_0000);
        send_op(FUNC_PUSH, 32'd0);
        send_op(FUNC_PICK, $urandom);          // dup
        send_op(FUNC_PUSH, 32'hffff_ffff);
        send_op(FUNC_PICK, $urandom);          // negative index
        send_op(FUNC_DROP, $urandom);
        send_op(FUNC_PUSH, 32'd5);
        send_op(FUNC_ROLL, $urandom);          // index past the bottom
        send_op(FUNC_DROP, $urandom);
        send_op(FUNC_PUSH, 32'd2);
        send_op(FUNC_ROLL, $urandom);
        send_op(FUNC_PUSH, 32'd0);
        send_op(FUNC_ROLL, $urandom);          // roll 0 only pops the index
        send_op(FUNC_DEPTH, $urandom);
        send_op(FUNC_SPARE_LO, $urandom);
        send_op(FUNC_SPARE_MID, $urandom);
        send_op(FUNC_SPARE_HI, $urandom);
        send_op(FUNC_DROP, $urandom);

        base  = sb.ops_noted;
        phase = 0;
        while (sb.ops_noted - base < RANDOM_OPS) begin
            // start with a full fill (overflow) and a full drain (underflow)
            mix    = (phase == 0) ? MIX_FILL : (phase == 1) ? MIX_DRAIN
                                             : t_mix'($urandom_range(0, 2));
            steady = (phase % 4 == 3);
            if (phase == 2 || phase == 6) long_hold_req = 1'b1;
            len = (phase < 2) ? 160 : $urandom_range(60, 140);
            repeat (len) random_op(mix);
            phase++;
        end
        i_in_valid <= 1'b0;
        steady     = 1'b0;

        while (sb.want_q.size() != 0) @(posedge i_clk);
        repeat (10) @(posedge i_clk);

        $display("ran %0d operations, %0d results; peak depth %0d of %0d",
                 sb.ops_noted, sb.results_seen, sb.peak_held, DEPTH);
        $display("results by code: ok %0d, underflow %0d, overflow %0d, bad index %0d",
                 sb.code_seen[ERR_OK], sb.code_seen[ERR_UNDERFLOW],
                 sb.code_seen[ERR_OVERFLOW], sb.code_seen[ERR_INDEX]);
        if (sb.mismatches == 0 && sb.want_q.size() == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule
